// File: hdl/llg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llg_pkg
// Shared constants, codes and elaboration-time table builders for the
// linear-light RGB gain block.
// ----------------------------------------------------------------------------
package llg_pkg;

    localparam int GAIN_SCALE_DEF   = 100;
    localparam int GAIN_FLOOR_DEF   = 0;
    localparam int GAIN_CEILING_DEF = 200;
    localparam int FRAC_BITS_DEF    = 24;

    localparam int CODE_W    = 8;
    localparam int GAIN_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int N_CHAN    = 3;
    localparam int N_CODES   = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL   = 2'd0,
        CFG_RED   = 2'd1,
        CFG_GREEN = 2'd2,
        CFG_BLUE  = 2'd3
    } t_cfg_idx;

    typedef logic [63:0] t_tab [N_CODES];

    // Q0.31 multiply with rounding
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + 64'h4000_0000) >> 31;
    endfunction

    function automatic logic [63:0] fifth_pow(input logic [63:0] y);
        logic [63:0] y2;
        y2 = qmul(y, y);
        return qmul(qmul(y2, y2), y);
    endfunction

    // linear light of code k/51000, unsigned Q1.f
    function automatic logic [63:0] linear_of(input logic [63:0] k, input int f);
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] v;
        if (k <= 64'd2062) begin
            return ((k << f) + 64'd329460) / 64'd658920;
        end
        t = (((k + 64'd2805) << 31) + 64'd26902) / 64'd53805;
        if (t > 64'h8000_0000) begin
            t = 64'h8000_0000;
        end
        s  = qmul(t, t);
        lo = 64'd0;
        hi = 64'h8000_0001;
        for (int i = 0; i < 40; i++) begin
            if (hi - lo > 64'd1) begin
                mid = lo + ((hi - lo) >> 1);
                if (fifth_pow(mid) <= s) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
        end
        v = qmul(s, lo);
        return ((v << f) + 64'h4000_0000) >> 31;
    endfunction

    function automatic t_tab build_dec(input int f);
        t_tab tab;
        for (int c = 0; c < N_CODES; c++) begin
            tab[c] = linear_of(64'(200 * c), f);
        end
        return tab;
    endfunction

    // entry c-1 holds the threshold of code c; last entry unused
    function automatic t_tab build_thr(input int f, input int scale);
        t_tab tab;
        for (int c = 1; c < N_CODES; c++) begin
            tab[c-1] = linear_of(64'(200 * c - 100), f) * 64'(scale);
        end
        tab[N_CODES-1] = 64'd0;
        return tab;
    endfunction

endpackage
`default_nettype wire

// File: hdl/llg_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llg_in_if
// Pixel input channel: valid/ready with three sRGB codes.
// ----------------------------------------------------------------------------
interface llg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green,
                    output pixel_blue, input ready);
    modport sink   (input valid, input pixel_red, input pixel_green,
                    input pixel_blue, output ready);
endinterface
`default_nettype wire

// File: hdl/llg_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llg_out_if
// Corrected pixel channel: valid/ready with three sRGB codes.
// ----------------------------------------------------------------------------
interface llg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] corrected_red;
    logic [7:0] corrected_green;
    logic [7:0] corrected_blue;

    modport source (output valid, output corrected_red, output corrected_green,
                    output corrected_blue, input ready);
    modport sink   (input valid, input corrected_red, input corrected_green,
                    input corrected_blue, output ready);
endinterface
`default_nettype wire

// File: hdl/linear_light_rgb_gain_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_light_rgb_gain_top
// Per-pixel white balance in linear light: sRGB decode ROM, gain multiply,
// and re-encode by a pipelined 8-step search of a threshold ROM.
// ----------------------------------------------------------------------------
// With calibration off the input codes pass through unchanged.
// Throughput: one word per cycle; the pipeline stalls as a whole only while
//   the output word waits on ready.
// Reset: synchronous active low; clears the pipeline valid bits and loads
//   calibration off with all gains at 100. ROMs are constant, no clear pass.
module linear_light_rgb_gain_top #(
    parameter int GAIN_SCALE           = llg_pkg::GAIN_SCALE_DEF,
    parameter int GAIN_FLOOR           = llg_pkg::GAIN_FLOOR_DEF,
    parameter int GAIN_CEILING         = llg_pkg::GAIN_CEILING_DEF,
    parameter int LINEAR_FRACTION_BITS = llg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [llg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [llg_pkg::GAIN_W-1:0]     i_cfg_data,
    llg_in_if.sink                              i_px,
    llg_out_if.source                           o_px
);
    import llg_pkg::*;

    // linear value needs F+1 bits (full scale is exactly 2^F); product and
    // thresholds fit in F+11 bits (gain < 2^10, scale <= 1000 < 2^10)
    localparam int LW     = LINEAR_FRACTION_BITS + 1;
    localparam int PW     = LINEAR_FRACTION_BITS + 11;
    localparam int LAST   = 9;        // output stage
    localparam int S_FIRST = 2;       // first search stage

    localparam t_tab DEC = build_dec(LINEAR_FRACTION_BITS);
    localparam t_tab THR = build_thr(LINEAR_FRACTION_BITS, GAIN_SCALE);
    localparam logic [PW-1:0] FULL_SCALE =
        PW'(64'(GAIN_SCALE) << LINEAR_FRACTION_BITS);

    // ---------------- configuration registers
    logic              r_cal;
    logic [GAIN_W-1:0] r_gain [N_CHAN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= 1'b0;
            for (int c = 0; c < N_CHAN; c++) begin
                r_gain[c] <= GAIN_W'(100);
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAL:   r_cal     <= i_cfg_data[0];
                CFG_RED:   r_gain[0] <= i_cfg_data;
                CFG_GREEN: r_gain[1] <= i_cfg_data;
                CFG_BLUE:  r_gain[2] <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // gain clamp: floor checked first
    logic [GAIN_W-1:0] gain_cl [N_CHAN];
    always_comb begin
        for (int c = 0; c < N_CHAN; c++) begin
            priority if (r_gain[c] < GAIN_W'(GAIN_FLOOR)) begin
                gain_cl[c] = GAIN_W'(GAIN_FLOOR);
            end else if (r_gain[c] > GAIN_W'(GAIN_CEILING)) begin
                gain_cl[c] = GAIN_W'(GAIN_CEILING);
            end else begin
                gain_cl[c] = r_gain[c];
            end
        end
    end

    // ---------------- pipeline
    logic              r_vld  [LAST+1];
    logic [CODE_W-1:0] r_code [LAST+1][N_CHAN];
    logic [LW-1:0]     r_lin  [N_CHAN];                    // stage 0
    logic [PW-1:0]     r_prod [1:LAST-1][N_CHAN];          // stages 1..8
    logic              r_fs   [S_FIRST:LAST][N_CHAN];
    logic [CODE_W-1:0] r_n    [S_FIRST:LAST][N_CHAN];
    logic [CODE_W-1:0] n_n    [S_FIRST:LAST][N_CHAN];

    logic              adv;
    logic [CODE_W-1:0] in_code [N_CHAN];

    assign adv        = !r_vld[LAST] || o_px.ready;
    assign i_px.ready = adv;
    assign in_code[0] = i_px.pixel_red;
    assign in_code[1] = i_px.pixel_green;
    assign in_code[2] = i_px.pixel_blue;

    // one search step per stage: try setting bit (LAST - s) of the code
    always_comb begin
        for (int s = S_FIRST; s <= LAST; s++) begin
            for (int c = 0; c < N_CHAN; c++) begin
                logic [CODE_W-1:0] prev;
                logic [CODE_W-1:0] cand;
                prev = (s == S_FIRST) ? '0 : r_n[s-1][c];
                cand = prev | (CODE_W'(1) << (LAST - s));
                if (r_prod[s-1][c] >= THR[cand - CODE_W'(1)][PW-1:0]) begin
                    n_n[s][c] = cand;
                end else begin
                    n_n[s][c] = prev;
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LAST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_px.valid;
            for (int s = 1; s <= LAST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // data path, no reset
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < N_CHAN; c++) begin
                // synchronous decode ROM read
                r_lin[c]     <= DEC[in_code[c]][LW-1:0];
                r_code[0][c] <= in_code[c];
                for (int s = 1; s <= LAST; s++) begin
                    r_code[s][c] <= r_code[s-1][c];
                end
                r_prod[1][c] <= PW'(r_lin[c]) * PW'(gain_cl[c]);
                for (int s = 2; s <= LAST - 1; s++) begin
                    r_prod[s][c] <= r_prod[s-1][c];
                end
                r_fs[S_FIRST][c] <= (r_prod[1][c] >= FULL_SCALE);
                for (int s = S_FIRST + 1; s <= LAST; s++) begin
                    r_fs[s][c] <= r_fs[s-1][c];
                end
                for (int s = S_FIRST; s <= LAST; s++) begin
                    r_n[s][c] <= n_n[s][c];
                end
            end
        end
    end

    // ---------------- output word
    logic [CODE_W-1:0] out_code [N_CHAN];
    always_comb begin
        for (int c = 0; c < N_CHAN; c++) begin
            if (!r_cal) begin
                out_code[c] = r_code[LAST][c];
            end else if (r_fs[LAST][c]) begin
                out_code[c] = '1;
            end else begin
                out_code[c] = r_n[LAST][c];
            end
        end
    end

    assign o_px.valid           = r_vld[LAST];
    assign o_px.corrected_red   = out_code[0];
    assign o_px.corrected_green = out_code[1];
    assign o_px.corrected_blue  = out_code[2];

endmodule
`default_nettype wire
